// ===== rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: command codes, status codes and
// the controller-to-datapath command/status structs. No dependencies.
package rau_pkg;

  localparam logic [2:0] CMD_NORM = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;
  localparam logic [2:0] CMD_EQ   = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic load;      // capture operands
    logic prod;      // register products
    logic comb;      // form num/den
    logic gcd_init;  // load gcd operands
    logic gcd_step;  // one binary gcd step
    logic div_init;  // start reduction divides
    logic div_step;  // one quotient bit for both divides
    logic fin;       // build result word
  } rau_cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
  } rau_sts_t;

endpackage

// ===== rtl/rau_datapath.sv =====
// Datapath: operand registers, multiplier stage, binary GCD and a restoring
// divider that reduces numerator and denominator together. Uses rau_pkg.
module rau_datapath #(
  parameter int WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rau_pkg::rau_cmd_t     cmd_i,
  output rau_pkg::rau_sts_t     sts_o,
  input  logic [2:0]            command_i,
  input  logic [WIDTH-1:0]      lhs_num_i,
  input  logic [WIDTH-1:0]      lhs_den_i,
  input  logic [WIDTH-1:0]      rhs_num_i,
  input  logic [WIDTH-2:0]      rhs_den_i,
  output logic [WIDTH-1:0]      result_num_o,
  output logic [WIDTH-2:0]      result_den_o,
  output logic                  is_equal_o,
  output logic [1:0]            status_o
);
  import rau_pkg::*;

  localparam int MW = WIDTH + 1;        // operand magnitude
  localparam int PW = 2 * MW;           // product magnitude
  localparam int SW = PW + 1;           // sum magnitude
  localparam int CW = $clog2(SW + 1);

  logic [2:0]    cmd_q;
  logic          an_q, bn_q, cn_q;
  logic [MW-1:0] am_q, bm_q, cm_q, dm_q;
  logic [PW-1:0] p0_q, p1_q, p2_q;
  logic          p0n_q, p1n_q, p2n_q;
  logic [SW-1:0] nm_q, dn_q;
  logic          neg_q;
  logic [SW-1:0] ga_q, gb_q;
  logic [CW-1:0] gk_q;
  logic [SW-1:0] g_q;
  logic [SW-1:0] qn_q, qd_q, rn_q, rd_q;
  logic [CW-1:0] cnt_q;

  function automatic logic [MW-1:0] mag(input logic [WIDTH-1:0] v);
    logic [MW-1:0] e;
    e = {v[WIDTH-1], v};
    return v[WIDTH-1] ? MW'(-e) : e;
  endfunction

  // operand capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      an_q  <= lhs_num_i[WIDTH-1];
      bn_q  <= lhs_den_i[WIDTH-1];
      cn_q  <= rhs_num_i[WIDTH-1];
      am_q  <= mag(lhs_num_i);
      bm_q  <= mag(lhs_den_i);
      cm_q  <= mag(rhs_num_i);
      dm_q  <= MW'(rhs_den_i);
    end
  end

  // product stage: pick the three products the command needs
  logic [MW-1:0] x0, y0, x1, y1, x2, y2;
  logic          s0, s1, s2;
  always_comb begin
    x0 = am_q; y0 = dm_q; s0 = an_q;          // a*d
    x1 = cm_q; y1 = bm_q; s1 = cn_q ^ bn_q;   // c*b
    x2 = bm_q; y2 = dm_q; s2 = bn_q;          // b*d
    case (cmd_q)
      CMD_NORM: begin
        x0 = am_q; y0 = MW'(1); s0 = an_q;
        x2 = bm_q; y2 = MW'(1); s2 = bn_q;
      end
      CMD_MUL: begin
        x0 = am_q; y0 = cm_q; s0 = an_q ^ cn_q;
      end
      CMD_DIV: begin
        x2 = bm_q; y2 = cm_q; s2 = bn_q ^ cn_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod) begin
      p0_q <= x0 * y0;  p0n_q <= s0;
      p1_q <= x1 * y1;  p1n_q <= s1 ^ (cmd_q == CMD_SUB);
      p2_q <= x2 * y2;  p2n_q <= s2;
    end
  end

  // combine: signed add for add/sub, else direct
  logic          an, bn2;
  logic [SW-1:0] sm;
  logic          sneg;
  always_comb begin
    an  = p0n_q && (p0_q != '0);
    bn2 = p1n_q && (p1_q != '0);
    if (an == bn2) begin
      sm = SW'(p0_q) + SW'(p1_q); sneg = an;
    end else if (p0_q >= p1_q) begin
      sm = SW'(p0_q - p1_q); sneg = an;
    end else begin
      sm = SW'(p1_q - p0_q); sneg = bn2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.comb) begin
      if (cmd_q == CMD_ADD || cmd_q == CMD_SUB) begin
        nm_q  <= sm;
        neg_q <= sneg ^ p2n_q;
      end else begin
        nm_q  <= SW'(p0_q);
        neg_q <= p0n_q ^ p2n_q;
      end
      dn_q <= SW'(p2_q);
    end
  end

  // binary gcd: strip common twos, then subtract; a zero operand ends it
  logic [SW-1:0] gdiff;
  logic          gdone;
  assign gdiff = (ga_q > gb_q) ? ga_q - gb_q : gb_q - ga_q;
  assign gdone = (gb_q == '0) || (ga_q == '0);
  always_ff @(posedge clk_i) begin
    if (cmd_i.gcd_init) begin
      ga_q <= nm_q;
      gb_q <= dn_q;
      gk_q <= '0;
    end else if (cmd_i.gcd_step && !gdone) begin
      if (!ga_q[0] && !gb_q[0]) begin
        ga_q <= ga_q >> 1; gb_q <= gb_q >> 1; gk_q <= gk_q + CW'(1);
      end else if (!ga_q[0]) begin
        ga_q <= ga_q >> 1;
      end else if (!gb_q[0]) begin
        gb_q <= gb_q >> 1;
      end else begin
        ga_q <= (ga_q < gb_q) ? ga_q : gb_q;
        gb_q <= gdiff >> 1;
      end
    end
  end
  assign sts_o.gcd_done = gdone;

  // restoring divide of both values by g, one bit per cycle
  logic [SW-1:0] rn_sh, rd_sh;
  assign rn_sh = {rn_q[SW-2:0], qn_q[SW-1]};
  assign rd_sh = {rd_q[SW-2:0], qd_q[SW-1]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      cnt_q <= CW'(SW);
    end else if (cmd_i.div_step && cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      g_q  <= ga_q << gk_q;
      qn_q <= nm_q; qd_q <= dn_q;
      rn_q <= '0;   rd_q <= '0;
    end else if (cmd_i.div_step && cnt_q != '0) begin
      if (rn_sh >= g_q) begin
        rn_q <= rn_sh - g_q; qn_q <= {qn_q[SW-2:0], 1'b1};
      end else begin
        rn_q <= rn_sh;       qn_q <= {qn_q[SW-2:0], 1'b0};
      end
      if (rd_sh >= g_q) begin
        rd_q <= rd_sh - g_q; qd_q <= {qd_q[SW-2:0], 1'b1};
      end else begin
        rd_q <= rd_sh;       qd_q <= {qd_q[SW-2:0], 1'b0};
      end
    end
  end
  assign sts_o.div_done = (cnt_q == '0);

  // result word
  localparam logic [SW-1:0] LIM = SW'(1) << (WIDTH - 1);
  logic eqv;
  assign eqv = (p0_q == p1_q) &&
               ((p0n_q && p0_q != '0) == (p1n_q && p1_q != '0));
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      result_num_o <= '0;
      result_den_o <= (WIDTH-1)'(1);
      is_equal_o   <= 1'b0;
      status_o     <= ST_OK;
      if (cmd_q == CMD_EQ) begin
        is_equal_o <= eqv;
      end else if (cmd_q <= CMD_DIV) begin
        if (dn_q == '0) begin
          status_o <= ST_DIV0;
        end else if (nm_q != '0) begin
          if (qd_q > LIM - SW'(1) || qn_q > (neg_q ? LIM : LIM - SW'(1))) begin
            status_o <= ST_OVF;
          end else begin
            result_num_o <= neg_q ? WIDTH'(-qn_q) : WIDTH'(qn_q);
            result_den_o <= (WIDTH-1)'(qd_q);
          end
        end
      end
    end
  end

endmodule

// ===== rtl/rau_ctrl.sv =====
// Controller: sequences load, multiply, combine, gcd, divide and output.
// Uses rau_pkg for the command and status structs.
module rau_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rau_pkg::rau_cmd_t cmd_o,
  input  rau_pkg::rau_sts_t sts_i
);
  import rau_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PROD = 3'd1;
  localparam logic [2:0] S_COMB = 3'd2;
  localparam logic [2:0] S_GINI = 3'd3;
  localparam logic [2:0] S_GCD  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       ov_q, ov_d;
  logic       take;

  // a new word is taken while the previous result waits, if it is taken too
  assign in_ready_o  = (state_q == S_IDLE) && (!ov_q || out_ready_i);
  assign out_valid_o = ov_q;
  assign take = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q && !out_ready_i;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = take;
        if (take) state_d = S_PROD;
      end
      S_PROD: begin cmd_o.prod = 1'b1; state_d = S_COMB; end
      S_COMB: begin cmd_o.comb = 1'b1; state_d = S_GINI; end
      S_GINI: begin cmd_o.gcd_init = 1'b1; state_d = S_GCD; end
      S_GCD: begin
        cmd_o.gcd_step = 1'b1;
        if (sts_i.gcd_done) begin
          cmd_o.gcd_step = 1'b0;
          cmd_o.div_init = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (!ov_d) begin
          cmd_o.fin = 1'b1;
          ov_d      = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: one fraction result per command word.
// The time per word is set by the binary GCD loop and the bit-serial reduction
// divider. One word in flight at a time.
// Reset (rst_ni low, asynchronous) returns the controller to idle and drops
// any pending result.
module rational_arithmetic_unit #(
  parameter int WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       command_i,
  input  logic [WIDTH-1:0] lhs_num_i,
  input  logic [WIDTH-1:0] lhs_den_i,
  input  logic [WIDTH-1:0] rhs_num_i,
  input  logic [WIDTH-2:0] rhs_den_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] result_num_o,
  output logic [WIDTH-2:0] result_den_o,
  output logic             is_equal_o,
  output logic [1:0]       status_o
);
  import rau_pkg::*;

  rau_cmd_t cmd;
  rau_sts_t sts;

  rau_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  rau_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .command_i, .lhs_num_i,
    .lhs_den_i, .rhs_num_i, .rhs_den_i, .result_num_o, .result_den_o,
    .is_equal_o, .status_o
  );

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != 2'd3)) else $error("bad status");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (result_num_o == '0 && !is_equal_o))
    else $error("error result not 0/1");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("overlap");

endmodule
